@@ hdl/tecp_pkg.sv @@
package tecp_pkg;

	// Coordinate format: signed, COORD_BITS wide (Q3.12)
	localparam int COORD_BITS = 16;
	// Edge and cut deltas need one more bit
	localparam int DIFF_BITS  = COORD_BITS + 1;
	// Single delta product
	localparam int MUL_BITS   = 2 * DIFF_BITS;
	// Cross products: den, tn, sn
	localparam int PROD_BITS  = MUL_BITS + 1;
	// Interpolation numerator sn * delta
	localparam int NUM_BITS   = PROD_BITS + DIFF_BITS;
	// Divider step counter
	localparam int CNT_BITS   = $clog2(DIFF_BITS);
	// APB address width (four 32-bit registers)
	localparam int ADDR_BITS  = 4;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic signed [MUL_BITS-1:0]   mul_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;
	typedef logic signed [NUM_BITS-1:0]   num_t;

	// Edge codes
	localparam logic [1:0] EDGE_AB = 2'd0;
	localparam logic [1:0] EDGE_BC = 2'd1;
	localparam logic [1:0] EDGE_CA = 2'd2;

	// Register indexes
	localparam logic [1:0] REG_CUT_START_X = 2'd0;
	localparam logic [1:0] REG_CUT_START_Y = 2'd1;
	localparam logic [1:0] REG_CUT_END_X   = 2'd2;
	localparam logic [1:0] REG_CUT_END_Y   = 2'd3;

	typedef struct packed {
		coord_t corner_a_x;
		coord_t corner_a_y;
		coord_t corner_a_z;
		coord_t corner_b_x;
		coord_t corner_b_y;
		coord_t corner_b_z;
		coord_t corner_c_x;
		coord_t corner_c_y;
		coord_t corner_c_z;
	} triangle_t;

	typedef struct packed {
		coord_t     hit_x;
		coord_t     hit_y;
		coord_t     hit_z;
		logic [1:0] edge_number;
		logic       last_of_triangle;
	} hit_t;

	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
	} cut_t;

	// One crossing edge, handed from front to back
	typedef struct packed {
		coord_t     e1_x;
		coord_t     e1_y;
		coord_t     e1_z;
		diff_t      d_x;
		diff_t      d_y;
		diff_t      d_z;
		prod_t      sn;
		prod_t      den;
		logic [1:0] edge_number;
		logic       last;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_PREP,
		BK_DIV,
		BK_DONE
	} back_state_t;

endpackage

@@ hdl/triangle_edge_cut_points.sv @@
// Triangle edge cut points. Each triangle item is tested edge by edge (a-b, b-c, c-a)
// against the cut segment from the four APB registers (byte addresses 0, 4, 8, 12).
// The front end tests one edge per cycle through its cross-product multipliers unless
// the queue is full, takes the next triangle as it tests the c-a edge, and queues up to
// four crossing edges. The back end turns each crossing into a hit point with a restoring
// divider per axis, all three in parallel, one quotient bit per cycle, and takes the
// next crossing only once the last hit is registered. Triangles without a crossing
// never reach the back end. Each result carries the edge number and a flag on the last hit of its triangle.
module triangle_edge_cut_points import tecp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  triangle_t            triangle,
	input  logic                 triangle_valid,
	output logic                 triangle_stall,
	output hit_t                 cut_hit,
	output logic                 hit_valid,
	input  logic                 hit_stall
);

	cut_t       cut_q;
	job_t       push_job, head_job;
	logic       push, full, nempty, pop;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cut_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_CUT_START_X: cut_q.start_x <= pwdata[COORD_BITS-1:0];
				REG_CUT_START_Y: cut_q.start_y <= pwdata[COORD_BITS-1:0];
				REG_CUT_END_X:   cut_q.end_x   <= pwdata[COORD_BITS-1:0];
				REG_CUT_END_Y:   cut_q.end_y   <= pwdata[COORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Register read
	always_comb begin
		case (reg_idx)
			REG_CUT_START_X: prdata = 32'(cut_q.start_x);
			REG_CUT_START_Y: prdata = 32'(cut_q.start_y);
			REG_CUT_END_X:   prdata = 32'(cut_q.end_x);
			REG_CUT_END_Y:   prdata = 32'(cut_q.end_y);
			default:         prdata = '0;
		endcase
	end

	tecp_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cut            (cut_q),
		.triangle       (triangle),
		.triangle_valid (triangle_valid),
		.triangle_stall (triangle_stall),
		.job            (push_job),
		.job_push       (push),
		.job_full       (full)
	);

	tecp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_job (push_job),
		.push   (push),
		.full   (full),
		.rd_job (head_job),
		.nempty (nempty),
		.pop    (pop)
	);

	tecp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (head_job),
		.job_valid (nempty),
		.job_pop   (pop),
		.cut_hit   (cut_hit),
		.hit_valid (hit_valid),
		.hit_stall (hit_stall)
	);

endmodule

@@ hdl/tecp_front.sv @@
module tecp_front import tecp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cut_t      cut,
	input  triangle_t triangle,
	input  logic      triangle_valid,
	output logic      triangle_stall,
	output job_t      job,
	output logic      job_push,
	input  logic      job_full
);

	triangle_t  tgl_q;
	logic       tgl_vld_q;
	logic [1:0] eidx_q;

	logic       vld_s1;
	logic [1:0] edge_s1;
	coord_t     e1x_s1, e1y_s1, e1z_s1;
	diff_t      ex_s1, ey_s1, ez_s1;
	mul_t       mden1_s1, mden2_s1, mtn1_s1, mtn2_s1, msn1_s1, msn2_s1;

	job_t       pend_q;
	logic       pend_vld_q;
	logic       pend_fin_q;

	coord_t     e1x, e1y, e1z, e2x, e2y, e2z;
	diff_t      ex, ey, ez, ax, ay, ox, oy;
	prod_t      den, tn, sn, nden, nsn;
	logic       hit, adv, take;

	function automatic logic in_unit(input prod_t n, input prod_t d);
		if (d > 0)
			return (n >= 0) && (n <= d);
		return (n <= 0) && (n >= d);
	endfunction

	// Edge endpoints for the current edge
	always_comb begin
		case (eidx_q)
			EDGE_AB: begin
				e1x = tgl_q.corner_a_x; e1y = tgl_q.corner_a_y; e1z = tgl_q.corner_a_z;
				e2x = tgl_q.corner_b_x; e2y = tgl_q.corner_b_y; e2z = tgl_q.corner_b_z;
			end
			EDGE_BC: begin
				e1x = tgl_q.corner_b_x; e1y = tgl_q.corner_b_y; e1z = tgl_q.corner_b_z;
				e2x = tgl_q.corner_c_x; e2y = tgl_q.corner_c_y; e2z = tgl_q.corner_c_z;
			end
			default: begin
				e1x = tgl_q.corner_c_x; e1y = tgl_q.corner_c_y; e1z = tgl_q.corner_c_z;
				e2x = tgl_q.corner_a_x; e2y = tgl_q.corner_a_y; e2z = tgl_q.corner_a_z;
			end
		endcase
	end

	// Deltas
	always_comb begin
		ex = diff_t'(e2x) - diff_t'(e1x);
		ey = diff_t'(e2y) - diff_t'(e1y);
		ez = diff_t'(e2z) - diff_t'(e1z);
		ax = diff_t'(cut.end_x) - diff_t'(cut.start_x);
		ay = diff_t'(cut.end_y) - diff_t'(cut.start_y);
		ox = diff_t'(cut.start_x) - diff_t'(e1x);
		oy = diff_t'(cut.start_y) - diff_t'(e1y);
	end

	// Crossing test on stage 1 products
	always_comb begin
		den  = prod_t'(mden1_s1) - prod_t'(mden2_s1);
		tn   = prod_t'(mtn1_s1) - prod_t'(mtn2_s1);
		sn   = prod_t'(msn1_s1) - prod_t'(msn2_s1);
		hit  = vld_s1 && (den != '0) && in_unit(tn, den) && in_unit(sn, den)
			&& !((tn == '0) && (sn == '0));
		nden = den[PROD_BITS-1] ? -den : den;
		nsn  = den[PROD_BITS-1] ? -sn : sn;
	end

	// Pending hit goes out once the next hit or the triangle end is known
	always_comb begin
		job_push = pend_vld_q && (hit || pend_fin_q);
		job      = pend_q;
		job.last = pend_fin_q;
		adv      = !(job_push && job_full);
		take     = !tgl_vld_q || (eidx_q == EDGE_CA);
		triangle_stall = !(adv && take);
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgl_vld_q  <= 1'b0;
			eidx_q     <= EDGE_AB;
			vld_s1     <= 1'b0;
			pend_vld_q <= 1'b0;
			pend_fin_q <= 1'b0;
		end else if (adv) begin
			vld_s1 <= tgl_vld_q;
			if (take) begin
				tgl_vld_q <= triangle_valid;
				eidx_q    <= EDGE_AB;
			end else begin
				eidx_q <= eidx_q + 2'd1;
			end
			if (hit) begin
				pend_vld_q <= 1'b1;
				pend_fin_q <= (edge_s1 == EDGE_CA);
			end else if (job_push) begin
				pend_vld_q <= 1'b0;
				pend_fin_q <= 1'b0;
			end else if (vld_s1 && (edge_s1 == EDGE_CA)) begin
				pend_fin_q <= pend_vld_q;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (adv) begin
			if (take && triangle_valid)
				tgl_q <= triangle;
			edge_s1  <= eidx_q;
			e1x_s1   <= e1x;
			e1y_s1   <= e1y;
			e1z_s1   <= e1z;
			ex_s1    <= ex;
			ey_s1    <= ey;
			ez_s1    <= ez;
			mden1_s1 <= mul_t'(ey) * mul_t'(ax);
			mden2_s1 <= mul_t'(ex) * mul_t'(ay);
			mtn1_s1  <= mul_t'(ex) * mul_t'(oy);
			mtn2_s1  <= mul_t'(ey) * mul_t'(ox);
			msn1_s1  <= mul_t'(ax) * mul_t'(oy);
			msn2_s1  <= mul_t'(ay) * mul_t'(ox);
			if (hit) begin
				pend_q.e1_x        <= e1x_s1;
				pend_q.e1_y        <= e1y_s1;
				pend_q.e1_z        <= e1z_s1;
				pend_q.d_x         <= ex_s1;
				pend_q.d_y         <= ey_s1;
				pend_q.d_z         <= ez_s1;
				pend_q.sn          <= nsn;
				pend_q.den         <= nden;
				pend_q.edge_number <= edge_s1;
				pend_q.last        <= 1'b0;
			end
		end
	end

endmodule

@@ hdl/tecp_queue.sv @@
module tecp_queue import tecp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  job_t wr_job,
	input  logic push,
	output logic full,
	output job_t rd_job,
	output logic nempty,
	input  logic pop
);

	localparam int DEPTH = 4;
	localparam int PTR_BITS = $clog2(DEPTH);

	job_t                mem [DEPTH];
	logic [PTR_BITS-1:0] wr_q, rd_q;
	logic [PTR_BITS:0]   cnt_q;
	logic                do_push, do_pop;

	always_comb begin
		full    = (cnt_q == (PTR_BITS+1)'(DEPTH));
		nempty  = (cnt_q != '0);
		do_push = push && !full;
		do_pop  = pop && nempty;
		rd_job  = mem[rd_q];
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_q] <= wr_job;
	end

endmodule

@@ hdl/tecp_back.sv @@
module tecp_back import tecp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  job_t job,
	input  logic job_valid,
	output logic job_pop,
	output hit_t cut_hit,
	output logic hit_valid,
	input  logic hit_stall
);

	back_state_t state_q, state_d;
	job_t        job_q;
	num_t        prod_q [3];
	logic [PROD_BITS-1:0] rem_q [3];
	logic [DIFF_BITS-1:0] low_q [3];
	logic [DIFF_BITS-1:0] quo_q [3];
	logic        neg_q [3];
	logic [CNT_BITS-1:0] cnt_q;
	hit_t        hit_q;
	logic        hit_vld_q;
	logic        out_free;

	diff_t       dsel [3];
	coord_t      esel [3];
	logic [NUM_BITS-1:0]  mag [3];
	logic [NUM_BITS-1:0]  nval [3];
	logic [PROD_BITS:0]   r2 [3];
	logic [PROD_BITS:0]   rsub [3];
	logic                 qbit [3];
	logic signed [DIFF_BITS:0]   qs [3];
	logic signed [DIFF_BITS+1:0] sum [3];
	coord_t      res [3];

	localparam logic signed [DIFF_BITS+1:0] CMAX = (DIFF_BITS+2)'((1 << (COORD_BITS-1)) - 1);
	localparam logic signed [DIFF_BITS+1:0] CMIN = -CMAX - (DIFF_BITS+2)'(1);

	assign out_free  = !hit_vld_q || !hit_stall;
	assign cut_hit   = hit_q;
	assign hit_valid = hit_vld_q;

	// Per-lane datapath: x, y, z
	always_comb begin
		dsel[0] = job_q.d_x;  esel[0] = job_q.e1_x;
		dsel[1] = job_q.d_y;  esel[1] = job_q.e1_y;
		dsel[2] = job_q.d_z;  esel[2] = job_q.e1_z;
		for (int k = 0; k < 3; k++) begin
			mag[k]  = prod_q[k][NUM_BITS-1] ? NUM_BITS'(-prod_q[k]) : NUM_BITS'(prod_q[k]);
			nval[k] = mag[k] + NUM_BITS'(job_q.den[PROD_BITS-1:1]);
			r2[k]   = {rem_q[k], low_q[k][DIFF_BITS-1]};
			rsub[k] = r2[k] - {1'b0, job_q.den};
			qbit[k] = (r2[k] >= {1'b0, job_q.den});
			qs[k]   = neg_q[k] ? -$signed({1'b0, quo_q[k]}) : $signed({1'b0, quo_q[k]});
			sum[k]  = (DIFF_BITS+2)'(esel[k]) + (DIFF_BITS+2)'(qs[k]);
			if (sum[k] > CMAX)
				res[k] = COORD_BITS'(CMAX);
			else if (sum[k] < CMIN)
				res[k] = COORD_BITS'(CMIN);
			else
				res[k] = COORD_BITS'(sum[k]);
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		job_pop = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					state_d = BK_MUL;
				end
			end
			BK_MUL:  state_d = BK_PREP;
			BK_PREP: state_d = BK_DIV;
			BK_DIV: begin
				if (cnt_q == CNT_BITS'(DIFF_BITS - 1))
					state_d = BK_DONE;
			end
			BK_DONE: begin
				if (out_free)
					state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			hit_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == BK_DONE) && out_free)
				hit_vld_q <= 1'b1;
			else if (!hit_stall)
				hit_vld_q <= 1'b0;
		end
	end

	// Multiply, then restoring division one quotient bit per cycle
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (job_valid)
					job_q <= job;
			end
			BK_MUL: begin
				for (int k = 0; k < 3; k++)
					prod_q[k] <= num_t'(job_q.sn) * num_t'(dsel[k]);
			end
			BK_PREP: begin
				cnt_q <= '0;
				for (int k = 0; k < 3; k++) begin
					neg_q[k] <= prod_q[k][NUM_BITS-1];
					rem_q[k] <= nval[k][NUM_BITS-1:DIFF_BITS];
					low_q[k] <= nval[k][DIFF_BITS-1:0];
				end
			end
			BK_DIV: begin
				cnt_q <= cnt_q + 1'b1;
				for (int k = 0; k < 3; k++) begin
					rem_q[k] <= qbit[k] ? rsub[k][PROD_BITS-1:0] : r2[k][PROD_BITS-1:0];
					low_q[k] <= {low_q[k][DIFF_BITS-2:0], 1'b0};
					quo_q[k] <= {quo_q[k][DIFF_BITS-2:0], qbit[k]};
				end
			end
			BK_DONE: begin
				if (out_free) begin
					hit_q.hit_x            <= res[0];
					hit_q.hit_y            <= res[1];
					hit_q.hit_z            <= res[2];
					hit_q.edge_number      <= job_q.edge_number;
					hit_q.last_of_triangle <= job_q.last;
				end
			end
			default: ;
		endcase
	end

endmodule
